// File: rtl/location_record_parser_defines.svh
// Assertion macros shared by the location record parser checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef LOCATION_RECORD_PARSER_DEFINES_SVH
`define LOCATION_RECORD_PARSER_DEFINES_SVH

// Condition a implies condition b in the same cycle, outside reset.
`define LRP_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("location_record_parser assertion failed");

// Condition a implies condition b in the next cycle, outside reset.
`define LRP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("location_record_parser assertion failed");

// Condition a implies condition b in the next cycle, checked during reset too.
`define LRP_ASSERT_ALWAYS_NEXT(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("location_record_parser assertion failed");

`endif

// File: rtl/lrp_pkg.sv
// Shared types, character codes and helper functions of the location record parser.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package lrp_pkg;

  localparam int BUCKET_COUNT = 127;
  localparam int BUCKET_BITS  = 7;
  localparam int COORD_BITS   = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [16:0] NUM_MAG_LIMIT = 17'd32768;
  localparam logic [15:0] NUM_POS_MAX   = 16'h7FFF;

  typedef enum logic [2:0] {
    EV_START,
    EV_ABSORB,
    EV_FINISH,
    EV_FINISH_END,
    EV_CLEAR
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
  } lex_ev_t;

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  // Remainder modulo 127: since 128 is 1 modulo 127, the 7-bit digits are summed
  // and the sum is folded until it fits, with 127 itself mapping to zero.
  function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [31:0] h);
    logic [9:0]             s1;
    logic [7:0]             s2;
    logic [BUCKET_BITS-1:0] s3;
    s1 = 10'(h[6:0]) + 10'(h[13:7]) + 10'(h[20:14]) + 10'(h[27:21]) + 10'(h[31:28]);
    s2 = 8'(s1[6:0]) + 8'(s1[9:7]);
    s3 = s2[6:0] + 7'(s2[7]);
    bucket_of = (s3 == 7'(BUCKET_COUNT)) ? '0 : s3;
  endfunction

endpackage

// File: rtl/lrp_byte_if.sv
// Valid/ready channel that carries one text byte per request.
// Depends on nothing.
`timescale 1ns / 1ps

interface lrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// File: rtl/lrp_rec_if.sv
// Valid/ready channel that carries one parsed location record per request.
// Depends on nothing.
`timescale 1ns / 1ps

interface lrp_rec_if;
  logic               valid;
  logic               ready;
  logic        [31:0] name_hash;
  logic        [6:0]  bucket;
  logic signed [15:0] level_number;
  logic signed [31:0] x_fixed;
  logic signed [31:0] y_fixed;

  modport source (output valid, output name_hash, output bucket, output level_number,
                  output x_fixed, output y_fixed, input ready);
  modport sink (input valid, input name_hash, input bucket, input level_number,
                input x_fixed, input y_fixed, output ready);
endinterface

// File: rtl/lrp_front.sv
// Lexer front end: tracks scan, token and comment modes and turns bytes into events.
// Depends on lrp_pkg and lrp_byte_if.
`timescale 1ns / 1ps

module lrp_front
  import lrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lrp_byte_if.sink  text_ch,
  output logic      push_valid,
  output lex_ev_t   push_ev,
  input  logic      push_ready
);

  typedef enum logic [1:0] {
    MODE_SCAN,
    MODE_TOKEN,
    MODE_COMMENT
  } mode_t;

  mode_t      lexer_mode;
  mode_t      lexer_mode_next;
  logic       emit;
  ev_kind_t   kind;
  logic [7:0] b;
  logic       accept;

  assign b              = text_ch.text_byte;
  assign text_ch.ready  = push_ready;
  assign accept         = text_ch.valid && push_ready;
  assign push_valid     = text_ch.valid && emit;
  assign push_ev.kind   = kind;
  assign push_ev.data   = b;

  always_comb begin
    lexer_mode_next = lexer_mode;
    emit            = 1'b0;
    kind            = EV_ABSORB;
    case (lexer_mode)
      MODE_COMMENT: begin
        if (b == CH_LF) begin
          lexer_mode_next = MODE_SCAN;
        end else if (b == CH_NUL) begin
          lexer_mode_next = MODE_SCAN;
          emit            = 1'b1;
          kind            = EV_CLEAR;
        end
      end
      MODE_TOKEN: begin
        emit = 1'b1;
        if (is_space(b)) begin
          lexer_mode_next = MODE_SCAN;
          kind            = EV_FINISH;
        end else if (b == CH_NUL) begin
          lexer_mode_next = MODE_SCAN;
          kind            = EV_FINISH_END;
        end else if (b == CH_HASH) begin
          lexer_mode_next = MODE_COMMENT;
          kind            = EV_FINISH;
        end
      end
      default: begin
        if (is_space(b)) begin
          lexer_mode_next = MODE_SCAN;
        end else if (b == CH_NUL) begin
          lexer_mode_next = MODE_SCAN;
          emit            = 1'b1;
          kind            = EV_CLEAR;
        end else if (b == CH_HASH) begin
          lexer_mode_next = MODE_COMMENT;
        end else begin
          lexer_mode_next = MODE_TOKEN;
          emit            = 1'b1;
          kind            = EV_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lexer_mode <= MODE_SCAN;
    end else if (accept) begin
      lexer_mode <= lexer_mode_next;
    end
  end

endmodule

// File: rtl/lrp_queue.sv
// Short event queue between the lexer front end and the field back end.
// Depends on lrp_pkg.
`timescale 1ns / 1ps

module lrp_queue
  import lrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  input  lex_ev_t push_ev,
  output logic    push_ready,
  output logic    pop_valid,
  output lex_ev_t pop_ev,
  input  logic    pop_ready
);

  lex_ev_t                mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_ev     = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lrp_back.sv
// Field back end: hash and number accumulation, field sequencing and the record register.
// Depends on lrp_pkg and lrp_rec_if.
`timescale 1ns / 1ps

module lrp_back
  import lrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  input  lex_ev_t    pop_ev,
  output logic       pop_ready,
  lrp_rec_if.source  rec_ch
);

  typedef enum logic [1:0] {
    PH_START,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  logic [1:0]             field_index;
  logic [31:0]            hash_acc;
  logic [16:0]            num_acc;
  logic                   num_neg;
  phase_t                 num_phase;
  logic [31:0]            held_hash;
  logic [BUCKET_BITS-1:0] held_bucket;
  logic [15:0]            held_level;
  logic [15:0]            held_x;

  logic [1:0]             field_index_next;
  logic [31:0]            hash_acc_next;
  logic [16:0]            num_acc_next;
  logic                   num_neg_next;
  phase_t                 num_phase_next;
  logic [31:0]            held_hash_next;
  logic [BUCKET_BITS-1:0] held_bucket_next;
  logic [15:0]            held_level_next;
  logic [15:0]            held_x_next;

  logic [31:0]            h_in;
  logic [16:0]            acc_in;
  logic                   neg_in;
  phase_t                 phase_in;
  logic [7:0]             b;
  logic [7:0]             c;
  logic [19:0]            prod;
  logic [15:0]            num_val;
  logic                   load_rec;
  logic                   pop;

  assign b         = pop_ev.data;
  assign pop_ready = !rec_ch.valid || rec_ch.ready;
  assign pop       = pop_valid && pop_ready;

  assign h_in     = (pop_ev.kind == EV_START) ? '0 : hash_acc;
  assign acc_in   = (pop_ev.kind == EV_START) ? '0 : num_acc;
  assign neg_in   = (pop_ev.kind == EV_START) ? 1'b0 : num_neg;
  assign phase_in = (pop_ev.kind == EV_START) ? PH_START : num_phase;

  assign c    = (b >= CH_LOW_A && b <= CH_LOW_Z) ? (b - CASE_BIT) : b;
  // Ten times the magnitude is formed from the 8x and 2x terms, and the new digit is added.
  assign prod = {acc_in, 3'b000} + {2'b00, acc_in, 1'b0} + 20'(b - CH_ZERO);

  always_comb begin
    if (num_neg) begin
      num_val = 16'(-num_acc);
    end else if (num_acc > 17'(NUM_POS_MAX)) begin
      num_val = NUM_POS_MAX;
    end else begin
      num_val = num_acc[15:0];
    end
  end

  always_comb begin
    field_index_next = field_index;
    hash_acc_next    = hash_acc;
    num_acc_next     = num_acc;
    num_neg_next     = num_neg;
    num_phase_next   = num_phase;
    held_hash_next   = held_hash;
    held_bucket_next = held_bucket;
    held_level_next  = held_level;
    held_x_next      = held_x;
    load_rec         = 1'b0;
    case (pop_ev.kind)
      EV_START, EV_ABSORB: begin
        hash_acc_next  = h_in;
        num_acc_next   = acc_in;
        num_neg_next   = neg_in;
        num_phase_next = phase_in;
        if (field_index == 2'd0) begin
          hash_acc_next = 32'(c) + (h_in << 6) + (h_in << 16) - h_in;
        end else if (phase_in != PH_STOPPED) begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            num_acc_next   = (prod > 20'(NUM_MAG_LIMIT)) ? NUM_MAG_LIMIT : prod[16:0];
            num_phase_next = PH_DIGITS;
          end else if (phase_in == PH_START && (b == CH_PLUS || b == CH_MINUS)) begin
            num_neg_next   = (b == CH_MINUS);
            num_phase_next = PH_DIGITS;
          end else begin
            num_phase_next = PH_STOPPED;
          end
        end
      end
      EV_FINISH, EV_FINISH_END: begin
        hash_acc_next  = '0;
        num_acc_next   = '0;
        num_neg_next   = 1'b0;
        num_phase_next = PH_START;
        case (field_index)
          2'd0: begin
            held_hash_next   = hash_acc;
            held_bucket_next = bucket_of(hash_acc);
            field_index_next = 2'd1;
          end
          2'd1: begin
            held_level_next  = num_val;
            field_index_next = 2'd2;
          end
          2'd2: begin
            held_x_next      = num_val;
            field_index_next = 2'd3;
          end
          default: begin
            load_rec         = 1'b1;
            field_index_next = 2'd0;
            held_hash_next   = '0;
            held_bucket_next = '0;
            held_level_next  = '0;
            held_x_next      = '0;
          end
        endcase
        if (pop_ev.kind == EV_FINISH_END) begin
          field_index_next = 2'd0;
          held_hash_next   = '0;
          held_bucket_next = '0;
          held_level_next  = '0;
          held_x_next      = '0;
        end
      end
      default: begin
        field_index_next = 2'd0;
        hash_acc_next    = '0;
        num_acc_next     = '0;
        num_neg_next     = 1'b0;
        num_phase_next   = PH_START;
        held_hash_next   = '0;
        held_bucket_next = '0;
        held_level_next  = '0;
        held_x_next      = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index <= 2'd0;
      hash_acc    <= '0;
      num_acc     <= '0;
      num_neg     <= 1'b0;
      num_phase   <= PH_START;
      held_hash   <= '0;
      held_bucket <= '0;
      held_level  <= '0;
      held_x      <= '0;
    end else if (pop) begin
      field_index <= field_index_next;
      hash_acc    <= hash_acc_next;
      num_acc     <= num_acc_next;
      num_neg     <= num_neg_next;
      num_phase   <= num_phase_next;
      held_hash   <= held_hash_next;
      held_bucket <= held_bucket_next;
      held_level  <= held_level_next;
      held_x      <= held_x_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_ch.valid <= 1'b0;
    end else if (pop && load_rec) begin
      rec_ch.valid <= 1'b1;
    end else if (rec_ch.ready) begin
      rec_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && load_rec) begin
      rec_ch.name_hash    <= held_hash;
      rec_ch.bucket       <= held_bucket;
      rec_ch.level_number <= held_level;
      rec_ch.x_fixed      <= {held_x, COORD_BITS'(0)};
      rec_ch.y_fixed      <= {num_val, COORD_BITS'(0)};
    end
  end

endmodule

// File: rtl/location_record_parser.sv
// Location record parser top level: lexer front end, event queue and field back end.
// Depends on lrp_pkg, lrp_byte_if, lrp_rec_if, lrp_front, lrp_queue and lrp_back.
`timescale 1ns / 1ps

// The parser takes one text byte per clock cycle while the event queue has room and emits one
// record each time the fourth token of a line group (name, level, x, y) ends. A byte that ends
// a y token is written into the two-entry event queue when it is accepted; the back end loads
// its record into the record register when the event leaves the queue, which waits while an
// earlier record is still held on the output. The input keeps taking bytes while a record
// waits to be taken, until the event queue fills.

module location_record_parser
  import lrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lrp_byte_if.sink   text_ch,
  lrp_rec_if.source  rec_ch
);

  logic    push_valid;
  lex_ev_t push_ev;
  logic    push_ready;
  logic    pop_valid;
  lex_ev_t pop_ev;
  logic    pop_ready;

  lrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_ch    (text_ch),
    .push_valid (push_valid),
    .push_ev    (push_ev),
    .push_ready (push_ready)
  );

  lrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ev    (push_ev),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_ev     (pop_ev),
    .pop_ready  (pop_ready)
  );

  lrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ev    (pop_ev),
    .pop_ready (pop_ready),
    .rec_ch    (rec_ch)
  );

endmodule

// File: rtl/lrp_checker.sv
// Port-level checker for the location record parser, attached to the top level by bind.
// Depends on lrp_pkg and location_record_parser_defines.svh.
`timescale 1ns / 1ps
`include "location_record_parser_defines.svh"

module lrp_checker
  import lrp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] name_hash,
  input logic [6:0]  bucket,
  input logic [31:0] x_fixed,
  input logic [31:0] y_fixed
);

  logic stalled;

  assign stalled = out_valid && !out_ready;

  `LRP_ASSERT_ALWAYS_NEXT(a_reset_clears_output, clk, rst, !out_valid)
  `LRP_ASSERT_NEXT(a_stalled_record_holds, clk, rst, stalled, out_valid && $stable(name_hash))
  `LRP_ASSERT_IMPL(a_bucket_in_range, clk, rst, out_valid, bucket < 7'(BUCKET_COUNT))
  `LRP_ASSERT_IMPL(a_coords_whole, clk, rst, out_valid, x_fixed[15:0] == 16'h0 && y_fixed[15:0] == 16'h0)

endmodule

bind location_record_parser lrp_checker u_lrp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (rec_ch.valid),
  .out_ready (rec_ch.ready),
  .name_hash (rec_ch.name_hash),
  .bucket    (rec_ch.bucket),
  .x_fixed   (rec_ch.x_fixed),
  .y_fixed   (rec_ch.y_fixed)
);
